// ===== hw/rtl/bsff_pkg.sv =====
// Shared types, field widths and action codes of the bit map set/find/fill block.
package bsff_pkg;

  localparam int IDX_W  = 13;
  localparam int POS_W  = 12;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_FILL = 2'd2;

  localparam logic             REG_SIZE_IN_USE = 1'b0;
  localparam logic [IDX_W-1:0] SIZE_RESET      = 13'd4096;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] start_index;
    logic [IDX_W-1:0] end_index;
    logic             bit_value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

// ===== hw/rtl/bsff_ifs.sv =====
// Request and result channel interfaces with valid/ready handshake.
interface bsff_req_if import bsff_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] start_index;
  logic [IDX_W-1:0] end_index;
  logic             bit_value;

  modport source (output valid, action, start_index, end_index, bit_value, input ready);
  modport sink   (input valid, action, start_index, end_index, bit_value, output ready);
endinterface

interface bsff_res_if import bsff_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

// ===== hw/rtl/bsff_lsb_enc.sv =====
// Priority encoder: index of the lowest set bit of a word.
module bsff_lsb_enc #(
  parameter int W  = 64,
  parameter int OW = 6
) (
  input  logic [W-1:0]  vec,
  output logic [OW-1:0] idx
);

  always_comb begin
    idx = '0;
    // scan downwards so the lowest set bit wins
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = OW'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/bsff_scan.sv =====
// Word store and the read-modify-write sequencer that serves set, find and fill.
module bsff_scan import bsff_pkg::*; #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] size_in,
  input  logic             req_valid,
  input  req_t             req,
  output logic             req_ready,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_take
);

  localparam int AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OW     = $clog2(WORD_BITS);
  localparam int SW     = OW + 1;
  localparam int BASE_W = IDX_W + 1;
  localparam int TOTAL  = WORD_BITS * WORD_COUNT;
  // floor(x / WORD_BITS) as (x * RECIP) >> SH, exact for all 13-bit x
  localparam int SH      = 20;
  localparam int RECIP   = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W = 18;
  localparam int PROD_W  = IDX_W + RECIP_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_BASE  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_r;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0]  quot_r, quot_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic              find_r, find_nxt;
  logic              val_r, val_nxt;
  logic              empty_r, empty_nxt;
  res_t              res_r, res_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  logic [IDX_W-1:0]     act_size;
  logic [IDX_W-1:0]     end_clip;
  logic [IDX_W-1:0]     end_eff;
  logic [PROD_W-1:0]    prod;
  logic [BASE_W-1:0]    lo_full;
  logic [BASE_W-1:0]    hi_full;
  logic [SW-1:0]        lo;
  logic [SW-1:0]        hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] match;
  logic [OW-1:0]        enc;
  logic                 last_word;

  assign act_size = (32'(size_in) < TOTAL) ? size_in : IDX_W'(TOTAL);
  assign end_clip = (req.end_index > act_size) ? act_size : req.end_index;

  always_comb begin
    unique case (req.action)
      ACT_SET:  end_eff = (req.start_index < act_size) ? req.start_index + 1'b1
                                                       : req.start_index;
      ACT_FIND: end_eff = end_clip;
      ACT_FILL: end_eff = end_clip;
      default:  end_eff = req.start_index;
    endcase
  end

  assign prod = PROD_W'(start_r) * PROD_W'(RECIP);

  // active bit window of the word under scan
  assign lo_full   = ({1'b0, start_r} > base_r) ? ({1'b0, start_r} - base_r) : '0;
  assign hi_full   = {1'b0, end_r} - base_r;
  assign lo        = SW'(lo_full);
  assign hi        = (hi_full >= BASE_W'(WORD_BITS)) ? SW'(WORD_BITS) : SW'(hi_full);
  assign mask      = ({WORD_BITS{1'b1}} << lo) & ~({WORD_BITS{1'b1}} << hi);
  assign match     = (val_r ? rdata_r : ~rdata_r) & mask;
  assign last_word = (hi_full <= BASE_W'(WORD_BITS));

  bsff_lsb_enc #(
    .W  (WORD_BITS),
    .OW (OW)
  ) u_enc (
    .vec (match),
    .idx (enc)
  );

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    addr_nxt     = addr_r;
    base_nxt     = base_r;
    quot_nxt     = quot_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    find_nxt     = find_r;
    val_nxt      = val_r;
    empty_nxt    = empty_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = (rdata_r & ~mask) | (val_r ? mask : '0);
    mem_re       = 1'b0;
    mem_raddr    = addr_r + 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          start_nxt = req.start_index;
          end_nxt   = end_eff;
          find_nxt  = (req.action == ACT_FIND);
          val_nxt   = req.bit_value;
          empty_nxt = !(req.start_index < end_eff);
          res_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        quot_nxt  = IDX_W'(prod >> SH);
        state_nxt = empty_r ? S_DONE : S_BASE;
      end
      S_BASE: begin
        base_nxt  = BASE_W'(quot_r * WORD_BITS);
        addr_nxt  = AW'(quot_r);
        mem_re    = 1'b1;
        mem_raddr = AW'(quot_r);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // fetch the next word while this one is checked or written back
        mem_re   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        base_nxt = base_r + BASE_W'(WORD_BITS);
        if (find_r) begin
          if (|match) begin
            res_nxt.found    = 1'b1;
            res_nxt.position = POS_W'(base_r + BASE_W'(enc));
            state_nxt        = S_DONE;
          end else if (last_word) begin
            state_nxt = S_DONE;
          end
        end else begin
          mem_we = 1'b1;
          if (last_word) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    base_r  <= base_nxt;
    quot_r  <= quot_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    find_r  <= find_nxt;
    val_r   <= val_nxt;
    empty_r <= empty_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

// ===== hw/rtl/bitmap_set_find_fill_core.sv =====
// Steps: the request is taken in idle, the quotient and then the word base are formed, each
// stored word touched is scanned in turn, then the result register is loaded once it is free;
// an empty range or unused action skips the word fetch. One request at a time: find and fill
// scan one stored word per cycle through the single read port and write port of the word store.
// Reset: synchronous, active low; the word store is then zeroed one word a cycle with
// in_item.ready low; configuration writes are taken throughout.
module bitmap_set_find_fill_core import bsff_pkg::*; #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  bsff_req_if.sink          in_item,
  bsff_res_if.source        out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [IDX_W-1:0] size_r;
  logic             out_valid_r;
  res_t             out_r;

  req_t             req;
  logic             req_ready;
  logic             res_valid;
  res_t             res;
  logic             res_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? DATA_W'(size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE)) begin
      size_r <= pwdata[IDX_W-1:0];
    end
  end

  assign req.action      = in_item.action;
  assign req.start_index = in_item.start_index;
  assign req.end_index   = in_item.end_index;
  assign req.bit_value   = in_item.bit_value;
  assign in_item.ready   = req_ready;

  bsff_scan #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .size_in   (size_r),
    .req_valid (in_item.valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // load the result register whenever it is empty or being drained
  assign res_take = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.found    = out_r.found;
  assign out_res.position = out_r.position;

endmodule
